// File: sv/msm_pkg.sv
// ----------------------------------------------------------------------------
// msm_pkg
// Shared types and constants for the mecanum chassis speed mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package msm_pkg;

  localparam int STICK_W    = 11;
  localparam int KEY_BITS_W = 16;
  localparam int YAW_W      = 13;
  localparam int CENTER_W   = 11;
  localparam int LIMIT_W    = 15;
  localparam int STEP_W     = 10;
  localparam int GEAR_W     = 3;
  localparam int STEP_PROD_W = STEP_W + GEAR_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int WHEEL_W    = 16;
  localparam int FOLLOW_W   = 11;

  localparam int FOLLOW_DEADBAND = 15;
  localparam int FOLLOW_LIMIT    = 900;

  localparam logic [KEY_BITS_W-1:0] KEY_MASK  = 16'h00ff;
  localparam logic [KEY_BITS_W-1:0] KEY_UP    = 16'h0001;
  localparam logic [KEY_BITS_W-1:0] KEY_DOWN  = 16'h0002;
  localparam logic [KEY_BITS_W-1:0] KEY_LEFT  = 16'h0004;
  localparam logic [KEY_BITS_W-1:0] KEY_RIGHT = 16'h0008;

  localparam logic [CENTER_W-1:0] CENTER_RST = 11'd1024;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 15'd4000;
  localparam logic [STEP_W-1:0]   STEP_RST   = 10'd660;
  localparam logic [STEP_W-1:0]   DIAG_RST   = 10'd330;
  localparam logic [YAW_W-1:0]    YAW_RST    = 13'd4096;
  localparam logic [GEAR_W-1:0]   GEAR_RST   = 3'd1;

  typedef enum logic [1:0] {
    MODE_PREPARE = 2'd0,
    MODE_STICK   = 2'd1,
    MODE_KEY     = 2'd2,
    MODE_STANDBY = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER = 3'd0,
    CFG_LIMIT  = 3'd1,
    CFG_STEP   = 3'd2,
    CFG_DIAG   = 3'd3,
    CFG_YAW    = 3'd4,
    CFG_GEAR   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [CENTER_W-1:0]    center;
    logic [LIMIT_W-1:0]     limit;
    logic [YAW_W-1:0]       yaw_center;
    logic [STEP_PROD_W-1:0] step;
    logic [STEP_PROD_W-1:0] diag;
  } cfg_t;

  typedef struct packed {
    mode_t                 mode;
    logic [STICK_W-1:0]    stick_x;
    logic [STICK_W-1:0]    stick_y;
    logic [KEY_BITS_W-1:0] key_bits;
    logic [YAW_W-1:0]      yaw;
  } item_t;

  typedef struct packed {
    logic                       active;
    logic signed [WHEEL_W-1:0]  tgt_a;
    logic signed [WHEEL_W-1:0]  tgt_b;
    logic signed [WHEEL_W-1:0]  tgt_c;
    logic signed [WHEEL_W-1:0]  tgt_d;
    logic signed [FOLLOW_W-1:0] follow;
  } tgt_t;

endpackage

`default_nettype wire

// File: sv/msm_cfg.sv
// ----------------------------------------------------------------------------
// msm_cfg
// Configuration registers with registered key step products.
// ----------------------------------------------------------------------------
`default_nettype none

module msm_cfg
  import msm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  logic [CENTER_W-1:0]    center_r;
  logic [LIMIT_W-1:0]     limit_r;
  logic [STEP_W-1:0]      step_r;
  logic [STEP_W-1:0]      diag_r;
  logic [YAW_W-1:0]       yaw_r;
  logic [GEAR_W-1:0]      gear_r;
  logic [STEP_PROD_W-1:0] step_prod_r;
  logic [STEP_PROD_W-1:0] diag_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= CENTER_RST;
      limit_r  <= LIMIT_RST;
      step_r   <= STEP_RST;
      diag_r   <= DIAG_RST;
      yaw_r    <= YAW_RST;
      gear_r   <= GEAR_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CENTER: center_r <= cfg_data[CENTER_W-1:0];
        CFG_LIMIT:  limit_r  <= cfg_data[LIMIT_W-1:0];
        CFG_STEP:   step_r   <= cfg_data[STEP_W-1:0];
        CFG_DIAG:   diag_r   <= cfg_data[STEP_W-1:0];
        CFG_YAW:    yaw_r    <= cfg_data[YAW_W-1:0];
        CFG_GEAR:   gear_r   <= cfg_data[GEAR_W-1:0];
        default: ;
      endcase
    end
  end

  // gear scaled offsets
  always_ff @(posedge clk) begin
    step_prod_r <= STEP_PROD_W'(gear_r) * STEP_PROD_W'(step_r);
    diag_prod_r <= STEP_PROD_W'(gear_r) * STEP_PROD_W'(diag_r);
  end

  assign cfg.center     = center_r;
  assign cfg.limit      = limit_r;
  assign cfg.yaw_center = yaw_r;
  assign cfg.step       = step_prod_r;
  assign cfg.diag       = diag_prod_r;

endmodule

`default_nettype wire

// File: sv/msm_target.sv
// ----------------------------------------------------------------------------
// msm_target
// Follow term, stick or key offsets, 1.6 scaling and mecanum wheel targets.
// ----------------------------------------------------------------------------
`default_nettype none

module msm_target
  import msm_pkg::*;
(
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output tgt_t       tgt
);

  localparam int DELTA_W    = 14;
  localparam int AXIS_W     = 15;
  localparam int AXIS_MAG_W = 14;
  localparam int DIV5_SHIFT = 18;
  localparam logic [15:0] DIV5_MUL = 16'd52429;

  // trunc(d * 8 / 5)
  function automatic logic signed [AXIS_W-1:0] scale_axis(
    input logic signed [DELTA_W-1:0] d
  );
    logic [DELTA_W-1:0]    mag;
    logic [15:0]           n;
    logic [31:0]           prod;
    logic [AXIS_MAG_W-1:0] q;
    logic signed [AXIS_W-1:0] qs;
    mag  = d[DELTA_W-1] ? unsigned'(-d) : unsigned'(d);
    n    = {mag[DELTA_W-2:0], 3'b000};
    prod = n * DIV5_MUL;
    q    = prod[DIV5_SHIFT +: AXIS_MAG_W];
    qs   = signed'({1'b0, q});
    return d[DELTA_W-1] ? -qs : qs;
  endfunction

  function automatic logic signed [FOLLOW_W-1:0] follow_of(
    input logic [YAW_W-1:0] yaw,
    input logic [YAW_W-1:0] center
  );
    logic signed [DELTA_W-1:0] err;
    logic signed [15:0]        e16;
    logic signed [15:0]        v;
    logic signed [15:0]        half;
    logic signed [15:0]        f;
    err  = signed'({1'b0, yaw}) - signed'({1'b0, center});
    e16  = 16'(err);
    v    = -(e16 + (e16 <<< 1));
    half = v[15] ? ((v + 16'sd1) >>> 1) : (v >>> 1);
    if (half < FOLLOW_DEADBAND && half > -FOLLOW_DEADBAND) begin
      f = '0;
    end else if (half > FOLLOW_LIMIT) begin
      f = 16'(FOLLOW_LIMIT);
    end else if (half < -FOLLOW_LIMIT) begin
      f = 16'(-FOLLOW_LIMIT);
    end else begin
      f = half;
    end
    return FOLLOW_W'(f);
  endfunction

  logic signed [DELTA_W-1:0]  dx;
  logic signed [DELTA_W-1:0]  dy;
  logic signed [DELTA_W-1:0]  s;
  logic signed [DELTA_W-1:0]  h;
  logic signed [AXIS_W-1:0]   x;
  logic signed [AXIS_W-1:0]   y;
  logic signed [WHEEL_W-1:0]  x16;
  logic signed [WHEEL_W-1:0]  y16;
  logic signed [WHEEL_W-1:0]  f16;
  logic signed [FOLLOW_W-1:0] f;
  logic                       active;

  always_comb begin
    dx     = '0;
    dy     = '0;
    active = 1'b0;
    s      = signed'({1'b0, cfg.step});
    h      = signed'({1'b0, cfg.diag});
    case (item.mode)
      MODE_STICK: begin
        active = 1'b1;
        dx = signed'({3'b000, item.stick_x}) - signed'({3'b000, cfg.center});
        dy = signed'({3'b000, item.stick_y}) - signed'({3'b000, cfg.center});
      end
      MODE_KEY: begin
        active = 1'b1;
        case (item.key_bits & KEY_MASK)
          KEY_UP | KEY_LEFT: begin
            dx = -h;
            dy = h;
          end
          KEY_UP | KEY_RIGHT: begin
            dx = h;
            dy = h;
          end
          KEY_DOWN | KEY_LEFT: begin
            dx = -h;
            dy = -h;
          end
          KEY_DOWN | KEY_RIGHT: begin
            dx = h;
            dy = -h;
          end
          KEY_UP:    dy = s;
          KEY_DOWN:  dy = -s;
          KEY_LEFT:  dx = -s;
          KEY_RIGHT: dx = s;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign f   = active ? follow_of(item.yaw, cfg.yaw_center) : '0;
  assign x   = scale_axis(dx);
  assign y   = scale_axis(dy);
  assign x16 = WHEEL_W'(x);
  assign y16 = WHEEL_W'(y);
  assign f16 = WHEEL_W'(f);

  assign tgt.active = active;
  assign tgt.tgt_a  = -x16 + y16 + f16;
  assign tgt.tgt_b  = x16 + y16 + f16;
  assign tgt.tgt_c  = x16 - y16 + f16;
  assign tgt.tgt_d  = -x16 - y16 + f16;
  assign tgt.follow = f;

endmodule

`default_nettype wire

// File: sv/msm_lane.sv
// ----------------------------------------------------------------------------
// msm_lane
// One wheel low-pass filter, 0.7 old + 0.3 target, with symmetric clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module msm_lane
  import msm_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       upd,
  input  wire logic signed [WHEEL_W-1:0]  target,
  input  wire logic [LIMIT_W-1:0]         limit,
  output logic signed [WHEEL_W-1:0]       filt,
  output logic signed [WHEEL_W-1:0]       filt_nxt
);

  localparam int ACC_W       = 20;
  localparam int MAG_W       = 19;
  localparam int PROD_W      = 38;
  localparam int DIV10_SHIFT = 22;
  localparam logic [MAG_W-1:0] DIV10_MUL = 19'd419431;

  logic signed [WHEEL_W-1:0] filt_r;
  logic signed [ACC_W-1:0]   old_x;
  logic signed [ACC_W-1:0]   tgt_x;
  logic signed [ACC_W-1:0]   acc;
  logic [MAG_W-1:0]          mag;
  logic [PROD_W-1:0]         prod;
  logic [WHEEL_W-1:0]        q;
  logic signed [WHEEL_W:0]   qs;
  logic signed [WHEEL_W:0]   v;
  logic signed [WHEEL_W:0]   lim_s;
  logic signed [WHEEL_W:0]   vc;

  always_comb begin
    old_x = ACC_W'(filt_r);
    tgt_x = ACC_W'(target);
    acc   = (old_x <<< 3) - old_x + (tgt_x <<< 1) + tgt_x;
    mag   = acc[ACC_W-1] ? MAG_W'(-acc) : MAG_W'(acc);
    prod  = mag * DIV10_MUL;
    q     = prod[DIV10_SHIFT +: WHEEL_W];
    qs    = signed'({1'b0, q});
    v     = acc[ACC_W-1] ? -qs : qs;
    lim_s = signed'({2'b00, limit});
    if (v > lim_s) begin
      vc = lim_s;
    end else if (v < -lim_s) begin
      vc = -lim_s;
    end else begin
      vc = v;
    end
    filt_nxt = WHEEL_W'(vc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= '0;
    end else if (upd) begin
      filt_r <= filt_nxt;
    end
  end

  assign filt = filt_r;

endmodule

`default_nettype wire

// File: sv/mecanum_chassis_speed_mixer_unit.sv
// ----------------------------------------------------------------------------
// mecanum_chassis_speed_mixer_unit
// Mecanum wheel mixer with follow term and per-wheel low-pass filter.
// ----------------------------------------------------------------------------
// path: a request moves through the request, wheel target and result registers
// throughput: one request per cycle while the result path is not stalled;
//   each lane's filter state loads in the same cycle as the result register
// reset: synchronous, clears all valid flags and the four filter states,
//   and restores the register defaults
`default_nettype none

module mecanum_chassis_speed_mixer_unit
  import msm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             in_mode,
  input  wire logic [STICK_W-1:0]     in_stick_x,
  input  wire logic [STICK_W-1:0]     in_stick_y,
  input  wire logic [KEY_BITS_W-1:0]  in_key_bits,
  input  wire logic [YAW_W-1:0]       in_yaw_position,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [WHEEL_W-1:0]   out_wheel_a,
  output logic signed [WHEEL_W-1:0]   out_wheel_b,
  output logic signed [WHEEL_W-1:0]   out_wheel_c,
  output logic signed [WHEEL_W-1:0]   out_wheel_d,
  output logic signed [FOLLOW_W-1:0]  out_follow_value,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t  cfg;
  item_t item1_r;
  tgt_t  tgt;
  tgt_t  tgt2_r;
  logic  v1_r;
  logic  v2_r;
  logic  v3_r;
  logic  act3_r;
  logic  en1;
  logic  en2;
  logic  en3;
  logic  upd;

  logic signed [WHEEL_W-1:0]  filt_a;
  logic signed [WHEEL_W-1:0]  filt_b;
  logic signed [WHEEL_W-1:0]  filt_c;
  logic signed [WHEEL_W-1:0]  filt_d;
  logic signed [WHEEL_W-1:0]  nxt_a;
  logic signed [WHEEL_W-1:0]  nxt_b;
  logic signed [WHEEL_W-1:0]  nxt_c;
  logic signed [WHEEL_W-1:0]  nxt_d;
  logic signed [WHEEL_W-1:0]  wheel_a_r;
  logic signed [WHEEL_W-1:0]  wheel_b_r;
  logic signed [WHEEL_W-1:0]  wheel_c_r;
  logic signed [WHEEL_W-1:0]  wheel_d_r;
  logic signed [FOLLOW_W-1:0] follow_r;

  msm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;
  assign upd      = en3 && v2_r && tgt2_r.active;

  // stage 1: request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      item1_r.mode     <= mode_t'(in_mode);
      item1_r.stick_x  <= in_stick_x;
      item1_r.stick_y  <= in_stick_y;
      item1_r.key_bits <= in_key_bits;
      item1_r.yaw      <= in_yaw_position;
    end
  end

  msm_target u_target (
    .item (item1_r),
    .cfg  (cfg),
    .tgt  (tgt)
  );

  // stage 2: wheel targets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      tgt2_r <= tgt;
    end
  end

  msm_lane u_lane_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (upd),
    .target   (tgt2_r.tgt_a),
    .limit    (cfg.limit),
    .filt     (filt_a),
    .filt_nxt (nxt_a)
  );

  msm_lane u_lane_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (upd),
    .target   (tgt2_r.tgt_b),
    .limit    (cfg.limit),
    .filt     (filt_b),
    .filt_nxt (nxt_b)
  );

  msm_lane u_lane_c (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (upd),
    .target   (tgt2_r.tgt_c),
    .limit    (cfg.limit),
    .filt     (filt_c),
    .filt_nxt (nxt_c)
  );

  msm_lane u_lane_d (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (upd),
    .target   (tgt2_r.tgt_d),
    .limit    (cfg.limit),
    .filt     (filt_d),
    .filt_nxt (nxt_d)
  );

  // stage 3: result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      act3_r    <= tgt2_r.active;
      wheel_a_r <= tgt2_r.active ? nxt_a : '0;
      wheel_b_r <= tgt2_r.active ? nxt_b : '0;
      wheel_c_r <= tgt2_r.active ? nxt_c : '0;
      wheel_d_r <= tgt2_r.active ? nxt_d : '0;
      follow_r  <= tgt2_r.follow;
    end
  end

  assign out_valid        = v3_r;
  assign out_wheel_a      = wheel_a_r;
  assign out_wheel_b      = wheel_b_r;
  assign out_wheel_c      = wheel_c_r;
  assign out_wheel_d      = wheel_d_r;
  assign out_follow_value = follow_r;

  a_idle_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !act3_r |-> out_wheel_a == '0 && out_wheel_b == '0 &&
      out_wheel_c == '0 && out_wheel_d == '0 && out_follow_value == '0)
    else $error("idle mode result not zero");

  a_state_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !upd |=> $stable(filt_a) && $stable(filt_b) && $stable(filt_c) &&
      $stable(filt_d))
    else $error("filter state moved without an active request");

  a_follow_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_follow_value <= 11'sd900 && out_follow_value >= -11'sd900 &&
      (out_follow_value == '0 || out_follow_value >= 11'sd15 ||
       out_follow_value <= -11'sd15))
    else $error("follow term out of range or inside deadband");

  a_ready_free : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

`default_nettype wire

// File: tb/tb_mecanum_chassis_speed_mixer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mecanum_chassis_speed_mixer_unit
// Self-checking bench for the mecanum chassis speed mixer. It sends directed
// and random control ticks under several register settings and random
// handshake stalls. Each wheel command and follow value is checked against a
// cycle-free integer model of the follow term, stick/key decode, mecanum mix
// and per-wheel low-pass filter with symmetric clamp.
// ----------------------------------------------------------------------------

import msm_pkg::*;

typedef struct packed {
  logic signed [WHEEL_W-1:0]  a;
  logic signed [WHEEL_W-1:0]  b;
  logic signed [WHEEL_W-1:0]  c;
  logic signed [WHEEL_W-1:0]  d;
  logic signed [FOLLOW_W-1:0] follow;
} wheel_cmd_t;

class mixer_scoreboard;
  int          center;
  int          limit;
  int          step;
  int          diag;
  int          yaw_center;
  int          gear;
  int          lane_a;
  int          lane_b;
  int          lane_c;
  int          lane_d;
  wheel_cmd_t  pending_cmds[$];
  int          errors;
  int          checked;

  function new();
    center     = CENTER_RST;
    limit      = LIMIT_RST;
    step       = STEP_RST;
    diag       = DIAG_RST;
    yaw_center = YAW_RST;
    gear       = GEAR_RST;
    lane_a     = 0;
    lane_b     = 0;
    lane_c     = 0;
    lane_d     = 0;
    errors     = 0;
    checked    = 0;
  endfunction

  function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      CFG_CENTER: center     = v[CENTER_W-1:0];
      CFG_LIMIT:  limit      = v[LIMIT_W-1:0];
      CFG_STEP:   step       = v[STEP_W-1:0];
      CFG_DIAG:   diag       = v[STEP_W-1:0];
      CFG_YAW:    yaw_center = v[YAW_W-1:0];
      CFG_GEAR:   gear       = v[GEAR_W-1:0];
      default: ;
    endcase
  endfunction

  function int lowpass(int old, int target);
    int v;
    v = (7 * old + 3 * target) / 10;
    if (v > limit) v = limit;
    if (v < -limit) v = -limit;
    return v;
  endfunction

  function void take_request(item_t it);
    wheel_cmd_t cmd;
    int err;
    int f;
    int dx;
    int dy;
    int s;
    int h;
    int x;
    int y;
    dx = 0;
    dy = 0;
    if (it.mode == MODE_PREPARE || it.mode == MODE_STANDBY) begin
      cmd = '0;
      pending_cmds.push_back(cmd);
      return;
    end
    err = int'(it.yaw) - yaw_center;
    f = (-err * 3) / 2;
    if (f < FOLLOW_DEADBAND && f > -FOLLOW_DEADBAND) f = 0;
    if (f > FOLLOW_LIMIT) f = FOLLOW_LIMIT;
    if (f < -FOLLOW_LIMIT) f = -FOLLOW_LIMIT;
    if (it.mode == MODE_STICK) begin
      dx = int'(it.stick_x) - center;
      dy = int'(it.stick_y) - center;
    end else begin
      s = gear * step;
      h = gear * diag;
      case (it.key_bits & KEY_MASK)
        KEY_UP | KEY_LEFT:    begin dx = -h; dy = h;  end
        KEY_UP | KEY_RIGHT:   begin dx = h;  dy = h;  end
        KEY_DOWN | KEY_LEFT:  begin dx = -h; dy = -h; end
        KEY_DOWN | KEY_RIGHT: begin dx = h;  dy = -h; end
        KEY_UP:    dy = s;
        KEY_DOWN:  dy = -s;
        KEY_LEFT:  dx = -s;
        KEY_RIGHT: dx = s;
        default: ;
      endcase
    end
    x = (dx * 8) / 5;
    y = (dy * 8) / 5;
    lane_a = lowpass(lane_a, -x + y + f);
    lane_b = lowpass(lane_b, x + y + f);
    lane_c = lowpass(lane_c, x - y + f);
    lane_d = lowpass(lane_d, -x - y + f);
    cmd.a      = lane_a[WHEEL_W-1:0];
    cmd.b      = lane_b[WHEEL_W-1:0];
    cmd.c      = lane_c[WHEEL_W-1:0];
    cmd.d      = lane_d[WHEEL_W-1:0];
    cmd.follow = f[FOLLOW_W-1:0];
    pending_cmds.push_back(cmd);
  endfunction

  function void check_wheels(wheel_cmd_t act);
    wheel_cmd_t want;
    int exp_v [5];
    int got_v [5];
    string lbl [5];
    if (pending_cmds.size() == 0) begin
      errors++;
      $display("%0t: wheel command with no request pending", $time);
      return;
    end
    want = pending_cmds.pop_front();
    checked++;
    lbl   = '{"wheel_a", "wheel_b", "wheel_c", "wheel_d", "follow_value"};
    exp_v = '{want.a, want.b, want.c, want.d, want.follow};
    got_v = '{act.a, act.b, act.c, act.d, act.follow};
    for (int i = 0; i < 5; i++) begin
      if (exp_v[i] != got_v[i]) begin
        errors++;
        $display("%0t: %s mismatch expected %0d actual %0d", $time, lbl[i], exp_v[i],
                 got_v[i]);
      end
    end
  endfunction
endclass

module tb_mecanum_chassis_speed_mixer_unit;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [1:0]                 in_mode = MODE_PREPARE;
  logic [STICK_W-1:0]         in_stick_x = '0;
  logic [STICK_W-1:0]         in_stick_y = '0;
  logic [KEY_BITS_W-1:0]      in_key_bits = '0;
  logic [YAW_W-1:0]           in_yaw_position = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [WHEEL_W-1:0]  out_wheel_a;
  logic signed [WHEEL_W-1:0]  out_wheel_b;
  logic signed [WHEEL_W-1:0]  out_wheel_c;
  logic signed [WHEEL_W-1:0]  out_wheel_d;
  logic signed [FOLLOW_W-1:0] out_follow_value;
  logic                       cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = CFG_CENTER;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  mixer_scoreboard sb = new();
  int in_idle_pct  = 31;
  int out_idle_pct = 65;
  int sent = 0;
  int settings = 1;

  mecanum_chassis_speed_mixer_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_stick_x       (in_stick_x),
    .in_stick_y       (in_stick_y),
    .in_key_bits      (in_key_bits),
    .in_yaw_position  (in_yaw_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_wheel_a      (out_wheel_a),
    .out_wheel_b      (out_wheel_b),
    .out_wheel_c      (out_wheel_c),
    .out_wheel_d      (out_wheel_d),
    .out_follow_value (out_follow_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    item_t req;
    if (rst_n && in_valid && in_ready) begin
      req.mode     = mode_t'(in_mode);
      req.stick_x  = in_stick_x;
      req.stick_y  = in_stick_y;
      req.key_bits = in_key_bits;
      req.yaw      = in_yaw_position;
      sb.take_request(req);
    end
  end

  always @(posedge clk) begin
    wheel_cmd_t act;
    if (rst_n && out_valid && out_ready) begin
      act.a      = out_wheel_a;
      act.b      = out_wheel_b;
      act.c      = out_wheel_c;
      act.d      = out_wheel_d;
      act.follow = out_follow_value;
      sb.check_wheels(act);
    end
  end

  function automatic item_t make_item(mode_t m, int sx, int sy, int keys, int yaw);
    item_t it;
    it.mode     = m;
    it.stick_x  = sx[STICK_W-1:0];
    it.stick_y  = sy[STICK_W-1:0];
    it.key_bits = keys[KEY_BITS_W-1:0];
    it.yaw      = yaw[YAW_W-1:0];
    return it;
  endfunction

  function automatic int random_stick();
    case ($urandom_range(5))
      0: return 0;
      1: return 2047;
      default: return int'($urandom_range(2047));
    endcase
  endfunction

  function automatic item_t random_item();
    item_t it;
    int sel;
    int yaw;
    logic [KEY_BITS_W-1:0] keys;
    sel = int'($urandom_range(9));
    if (sel < 4) it.mode = MODE_STICK;
    else if (sel < 8) it.mode = MODE_KEY;
    else if (sel == 8) it.mode = MODE_PREPARE;
    else it.mode = MODE_STANDBY;
    it.stick_x = STICK_W'(random_stick());
    it.stick_y = STICK_W'(random_stick());
    case ($urandom_range(11))
      0: keys = KEY_UP;
      1: keys = KEY_DOWN;
      2: keys = KEY_LEFT;
      3: keys = KEY_RIGHT;
      4: keys = KEY_UP | KEY_LEFT;
      5: keys = KEY_UP | KEY_RIGHT;
      6: keys = KEY_DOWN | KEY_LEFT;
      7: keys = KEY_DOWN | KEY_RIGHT;
      8: keys = '0;
      9: keys = KEY_UP | KEY_DOWN;
      default: keys = KEY_BITS_W'($urandom_range(16'hffff));
    endcase
    if ($urandom_range(3) == 0) keys[15:8] = 8'($urandom_range(8'hff));
    it.key_bits = keys;
    if ($urandom_range(2) != 0) yaw = sb.yaw_center + int'($urandom_range(1400)) - 700;
    else yaw = int'($urandom_range(8191));
    it.yaw = yaw[YAW_W-1:0];
    return it;
  endfunction

  task automatic drive_request(item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= it.mode;
    in_stick_x      <= it.stick_x;
    in_stick_y      <= it.stick_y;
    in_key_bits     <= it.key_bits;
    in_yaw_position <= it.yaw;
    sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(cfg_idx_t idx, int v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_reg(idx, v[CFG_DATA_W-1:0]);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_directed();
    drive_request(make_item(MODE_PREPARE, 2047, 2047, 16'hffff, 8191));
    drive_request(make_item(MODE_STICK, 2047, 2047, 0, 4096));
    drive_request(make_item(MODE_STICK, 0, 0, 0, 4096));
    drive_request(make_item(MODE_STANDBY, 0, 0, 0, 0));
    drive_request(make_item(MODE_STICK, 0, 2047, 0, 4096));
    drive_request(make_item(MODE_STICK, 2047, 0, 0, 4096));
    drive_request(make_item(MODE_KEY, 0, 0, KEY_UP, 4096));
    drive_request(make_item(MODE_KEY, 0, 0, KEY_DOWN, 4096));
    drive_request(make_item(MODE_KEY, 0, 0, KEY_LEFT, 4096));
    drive_request(make_item(MODE_KEY, 0, 0, KEY_RIGHT, 4096));
    drive_request(make_item(MODE_KEY, 0, 0, KEY_UP | KEY_LEFT, 4096));
    drive_request(make_item(MODE_KEY, 0, 0, KEY_UP | KEY_RIGHT, 4096));
    drive_request(make_item(MODE_KEY, 0, 0, KEY_DOWN | KEY_LEFT, 4096));
    drive_request(make_item(MODE_KEY, 0, 0, KEY_DOWN | KEY_RIGHT, 4096));
    drive_request(make_item(MODE_KEY, 0, 0, KEY_UP | KEY_DOWN, 4096));
    drive_request(make_item(MODE_KEY, 0, 0, 16'hff01, 4096));
    drive_request(make_item(MODE_KEY, 0, 0, 16'h0011, 4096));
    // yaw error at the deadband edges and the follow clamp
    drive_request(make_item(MODE_STICK, 1024, 1024, 0, 4096 + 9));
    drive_request(make_item(MODE_STICK, 1024, 1024, 0, 4096 + 10));
    drive_request(make_item(MODE_STICK, 1024, 1024, 0, 4096 - 10));
    drive_request(make_item(MODE_KEY, 0, 0, 0, 4096 - 601));
    drive_request(make_item(MODE_KEY, 0, 0, 0, 4096 + 601));
    drive_request(make_item(MODE_STICK, 2047, 2047, 0, 0));
    drive_request(make_item(MODE_STICK, 0, 0, 0, 8191));
  endtask

  task automatic apply_setting(int p);
    case (p)
      1: begin
        write_reg(CFG_CENTER, 2047);
        write_reg(CFG_LIMIT, 16384);
        write_reg(CFG_STEP, 1023);
        write_reg(CFG_DIAG, 1023);
        write_reg(CFG_YAW, 8191);
        write_reg(CFG_GEAR, 7);
      end
      2: begin
        write_reg(CFG_CENTER, 0);
        write_reg(CFG_LIMIT, 0);
        write_reg(CFG_STEP, 0);
        write_reg(CFG_DIAG, 0);
        write_reg(CFG_YAW, 0);
        write_reg(CFG_GEAR, 0);
      end
      3: begin
        write_reg(CFG_CENTER, $urandom_range(2047));
        write_reg(CFG_LIMIT, $urandom_range(16384));
        write_reg(CFG_STEP, $urandom_range(1023));
        write_reg(CFG_DIAG, $urandom_range(1023));
        write_reg(CFG_YAW, $urandom_range(8191));
        write_reg(CFG_GEAR, $urandom_range(7));
      end
      default: begin
        write_reg(CFG_CENTER, $urandom_range(1200, 850));
        write_reg(CFG_LIMIT, $urandom_range(6000, 200));
        write_reg(CFG_STEP, $urandom_range(1023));
        write_reg(CFG_DIAG, $urandom_range(1023));
        write_reg(CFG_YAW, $urandom_range(8191));
        write_reg(CFG_GEAR, $urandom_range(7));
      end
    endcase
  endtask

  initial begin
    int phase_items [5];
    phase_items = '{230, 230, 60, 400, 230};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < 5; p++) begin
      if (p < 2) begin
        in_idle_pct  = 31;
        out_idle_pct = 65;
      end else if (p < 4) begin
        in_idle_pct  = 65;
        out_idle_pct = 31;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      if (p == 0) begin
        run_directed();
      end else begin
        apply_setting(p);
        settings++;
      end
      for (int i = 0; i < phase_items[p]; i++) drive_request(random_item());
      wait_idle();
    end
    $display("sent %0d requests over %0d register settings, checked %0d wheel commands",
             sent, settings, sb.checked);
    $display("covered stick and key modes, prepare and standby, deadband and clamps");
    if (sb.errors == 0 && sb.pending_cmds.size() == 0) begin
      $display("mecanum_chassis_speed_mixer_unit verification clean");
    end else begin
      $display("mecanum_chassis_speed_mixer_unit verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d wheel commands outstanding", sb.pending_cmds.size());
    $display("mecanum_chassis_speed_mixer_unit verification failed");
    $finish;
  end

endmodule
